FILE: hdl/sam_pkg.sv
// Shared widths, register indexes, pixel record and helpers of the segment-aware mean filter.
package sam_pkg;

  localparam int DEF_MAX_WIDTH           = 1024;
  localparam int DEF_SAME_RADIUS         = 5;
  localparam int DEF_MAX_ADAPTIVE_RADIUS = 4;

  localparam int COLOUR_W     = 8;
  localparam int LABEL_W      = 8;
  localparam int DIST_W       = 16;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 13;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // item kinds
  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // one stored pixel
  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic [LABEL_W-1:0]  label;
    logic                sal;
    logic [DIST_W-1:0]   distance;
  } pix_t;

  localparam int PIX_W = $bits(pix_t);

  // floor(10*(d+0.3)) clamped to 4..9, then halved
  function automatic logic [3:0] adaptive_radius(input logic [DIST_W-1:0] dd);
    logic [DIST_W+3:0] p;
    logic [7:0]        a;
    p = {dd, 3'b000} + {3'b000, dd, 1'b0};
    a = p[DIST_W+3:12] + 8'd3;
    if (a < 8'd4) a = 8'd4;
    if (a > 8'd9) a = 8'd9;
    return a[4:1];
  endfunction

endpackage

FILE: hdl/sam_ifs.sv
// Channel interfaces: pixel input, filtered result and configuration write.
interface sam_in_if import sam_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic [LABEL_W-1:0]  segment_label;
  logic                salient;
  logic [DIST_W-1:0]   distance;
  modport source (output valid, func, red, green, blue, segment_label, salient, distance,
                  input ready);
  modport sink (input valid, func, red, green, blue, segment_label, salient, distance,
                output ready);
endinterface

interface sam_out_if import sam_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] out_red;
  logic [COLOUR_W-1:0] out_green;
  logic [COLOUR_W-1:0] out_blue;
  logic                last_of_frame;
  modport source (output valid, out_red, out_green, out_blue, last_of_frame, input ready);
  modport sink (input valid, out_red, out_green, out_blue, last_of_frame, output ready);
endinterface

interface sam_cfg_if import sam_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/sam_ram.sv
// Generic simple dual-port RAM with registered read.
module sam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/sam_div.sv
// Restoring divider: three channel sums by one shared count, one quotient bit per cycle.
module sam_div import sam_pkg::*; #(
  parameter int SUM_W = 16,
  parameter int CNT_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [2:0][SUM_W-1:0]         sum_i,
  input  logic [CNT_W-1:0]              cnt_i,
  output logic                          done,
  output logic [2:0][COLOUR_W-1:0]      quot
);
  localparam int DW = CNT_W + COLOUR_W - 1;
  localparam int SW = $clog2(COLOUR_W + 1);

  logic [2:0][SUM_W-1:0]    rem_r;
  logic [2:0][COLOUR_W-1:0] q_r;
  logic [DW-1:0]            den_r;
  logic [SW-1:0]            step_r;
  logic                     busy_r;
  logic                     done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= sum_i;
        q_r    <= '0;
        den_r  <= DW'(cnt_i) << (COLOUR_W - 1);
      end else if (busy_r) begin
        // one quotient bit per channel
        for (int c = 0; c < 3; c++) begin
          if (rem_r[c] >= SUM_W'(den_r)) begin
            rem_r[c] <= rem_r[c] - SUM_W'(den_r);
            q_r[c]   <= {q_r[c][COLOUR_W-2:0], 1'b1};
          end else begin
            q_r[c]   <= {q_r[c][COLOUR_W-2:0], 1'b0};
          end
        end
        den_r  <= den_r >> 1;
        step_r <= step_r + 1'b1;
        if (32'(step_r) == COLOUR_W - 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: hdl/segment_aware_mean_filter_core.sv
// Segment-aware mean filter: line store in RAM, one window read per cycle, iterative mean.
// An item is accepted only while idle, so the sweep of each window over the single read port
// of the line store, once per window position, and the 8 divider steps end before the next item.
// Reset: synchronous active-low; frame counters clear, registers return to 640 x 480.
// The line store needs no clearing: only positions written in the current frame are read.
module segment_aware_mean_filter_core import sam_pkg::*; #(
  parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
  parameter int SAME_RADIUS         = DEF_SAME_RADIUS,
  parameter int MAX_ADAPTIVE_RADIUS = DEF_MAX_ADAPTIVE_RADIUS
) (
  input logic        clk,
  input logic        rst_n,
  sam_in_if.sink     in_ch,
  sam_out_if.source  out_ch,
  sam_cfg_if.sink    cfg_ch
);
  localparam int LAG   = (SAME_RADIUS > MAX_ADAPTIVE_RADIUS) ? SAME_RADIUS : MAX_ADAPTIVE_RADIUS;
  localparam int WIN   = 2 * LAG + 1;
  localparam int DEPTH = (2 * LAG + 2) * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RW    = HEIGHT_CFG_W;
  localparam int KW    = $clog2(WIN);
  localparam int CNT_W = $clog2(WIN * WIN + 1);
  localparam int SUM_W = COLOUR_W + CNT_W;
  localparam int LW    = $clog2(LAG * MAX_WIDTH + LAG + 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_CTR, ST_CLAT, ST_SWEEP, ST_TAIL, ST_DSTART, ST_DWAIT, ST_DONE
  } state_t;

  state_t state_r;

  logic [WIDTH_CFG_W-1:0]  width_cfg_r;
  logic [HEIGHT_CFG_W-1:0] height_cfg_r;
  logic [WW-1:0] w;
  logic [RW-1:0] h;
  logic [LW-1:0] lag;
  logic [AW-1:0] lag_rows;

  // frame position counters
  logic [CW-1:0] in_col_r, out_col_r, wcol_r;
  logic [RW-1:0] in_row_r, out_row_r, wrow_r;
  logic [AW-1:0] in_addr_r, out_addr_r, waddr_r;
  logic [LW-1:0] lead_r;
  logic          drain_r;
  logic          wlast_r;

  // centre and sweep
  logic [LABEL_W-1:0] ctr_label_r;
  logic               ctr_sal_r;
  logic [DIST_W-1:0]  ctr_dist_r;
  logic [3:0]         rad_r;
  logic [KW-1:0]      kr_r, kc_r;
  logic [AW-1:0]      rb_r;
  logic               tag_v_r, tag_same_r, tag_adap_r;
  logic [2:0][SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]   cnt_r;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;
  pix_t          rd;

  // divider
  logic                     div_start, div_done;
  logic [2:0][COLOUR_W-1:0] quot;

  // output register
  logic                out_valid_r;
  logic [COLOUR_W-1:0] o_red_r, o_green_r, o_blue_r;
  logic                o_last_r;

  logic in_acc, cfg_acc, emit;

  // effective frame size
  always_comb begin
    if (width_cfg_r == '0) w = WW'(1);
    else if (32'(width_cfg_r) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(width_cfg_r);
    h        = (height_cfg_r == '0) ? RW'(1) : height_cfg_r;
    lag      = LW'(LAG * 32'(w) + LAG);
    lag_rows = AW'(LAG * 32'(w));
  end

  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign emit         = (in_row_r >= h) || (!drain_r && (lead_r > lag));

  // pixel write into the line store
  assign ram_we    = in_acc && (in_ch.func == FUNC_PIXEL);
  assign ram_wdata = {in_ch.red, in_ch.green, in_ch.blue, in_ch.segment_label,
                      in_ch.salient, in_ch.distance};
  assign rd        = pix_t'(ram_rdata);

  // neighbour address and image bounds for the current sweep position
  logic signed [AW+1:0] a_t;
  logic signed [RW+1:0] rr;
  logic signed [CW+1:0] cc;
  logic                 inimg, in_same, in_adap;
  always_comb begin
    a_t = $signed({2'b00, rb_r}) + $signed((AW+2)'(kc_r)) - $signed((AW+2)'(LAG));
    if (a_t < 0) a_t = a_t + $signed((AW+2)'(DEPTH));
    else if (a_t >= $signed((AW+2)'(DEPTH))) a_t = a_t - $signed((AW+2)'(DEPTH));
    rr = $signed({2'b00, wrow_r}) + $signed((RW+2)'(kr_r)) - $signed((RW+2)'(LAG));
    cc = $signed({2'b00, wcol_r}) + $signed((CW+2)'(kc_r)) - $signed((CW+2)'(LAG));
    inimg = (rr >= 0) && (rr < $signed({2'b00, h})) &&
            (cc >= 0) && (cc < $signed((CW+2)'(w)));
    in_same = (32'(kr_r) >= LAG - SAME_RADIUS) && (32'(kr_r) <= LAG + SAME_RADIUS) &&
              (32'(kc_r) >= LAG - SAME_RADIUS) && (32'(kc_r) <= LAG + SAME_RADIUS);
    in_adap = (32'(kr_r) + 32'(rad_r) >= LAG) && (32'(kr_r) <= LAG + 32'(rad_r)) &&
              (32'(kc_r) + 32'(rad_r) >= LAG) && (32'(kc_r) <= LAG + 32'(rad_r));
    if (state_r == ST_SWEEP) ram_raddr = AW'(a_t);
    else ram_raddr = waddr_r;
  end

  // neighbour acceptance on returned data
  logic [DIST_W-1:0]   diff;
  logic [DIST_W+3:0]   diff10;
  logic [DIST_W+1:0]   dist3;
  logic                take;
  always_comb begin
    diff   = (rd.distance > ctr_dist_r) ? rd.distance - ctr_dist_r : ctr_dist_r - rd.distance;
    diff10 = {diff, 3'b000} + {3'b000, diff, 1'b0};
    dist3  = {ctr_dist_r, 1'b0} + {2'b00, ctr_dist_r};
    take   = tag_v_r &&
             ((tag_same_r && (rd.label == ctr_label_r)) ||
              (!ctr_sal_r && tag_adap_r && (rd.label != ctr_label_r) &&
               (diff10 < (DIST_W+4)'(dist3))));
  end

  assign div_start = (state_r == ST_DSTART);

  // controller and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      width_cfg_r  <= WIDTH_RESET;
      height_cfg_r <= HEIGHT_RESET;
      in_col_r     <= '0;
      in_row_r     <= '0;
      in_addr_r    <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      out_addr_r   <= '0;
      lead_r       <= '0;
      drain_r      <= 1'b0;
      tag_v_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_ch.ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      if (state_r != ST_SWEEP) tag_v_r <= 1'b0;
      if (take) begin
        sum_r[0] <= sum_r[0] + SUM_W'(rd.red);
        sum_r[1] <= sum_r[1] + SUM_W'(rd.green);
        sum_r[2] <= sum_r[2] + SUM_W'(rd.blue);
        cnt_r    <= cnt_r + 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (cfg_acc) begin
            if (cfg_ch.index == CFG_IMAGE_WIDTH) width_cfg_r <= cfg_ch.data[WIDTH_CFG_W-1:0];
            else height_cfg_r <= cfg_ch.data[HEIGHT_CFG_W-1:0];
            in_col_r <= '0; in_row_r <= '0; in_addr_r <= '0;
            out_col_r <= '0; out_row_r <= '0; out_addr_r <= '0;
            lead_r <= '0;
          end else if (in_acc) begin
            drain_r <= (in_ch.func == FUNC_DRAIN);
            state_r <= ST_DECIDE;
            if (in_ch.func == FUNC_PIXEL) begin
              // the write address was chosen combinationally; a completed frame restarts
              if (in_row_r >= h) begin
                out_col_r <= '0; out_row_r <= '0; out_addr_r <= '0;
                lead_r    <= LW'(1);
                in_addr_r <= AW'(1);
                in_row_r  <= (w == WW'(1)) ? RW'(1) : '0;
                in_col_r  <= (w == WW'(1)) ? '0 : CW'(1);
              end else begin
                lead_r    <= lead_r + 1'b1;
                in_addr_r <= (32'(in_addr_r) + 1 == DEPTH) ? '0 : in_addr_r + 1'b1;
                if (32'(in_col_r) + 1 >= 32'(w)) begin
                  in_col_r <= '0;
                  in_row_r <= in_row_r + 1'b1;
                end else begin
                  in_col_r <= in_col_r + 1'b1;
                end
              end
            end
          end
        end
        ST_DECIDE: begin
          if (emit) begin
            wrow_r  <= out_row_r;
            wcol_r  <= out_col_r;
            waddr_r <= out_addr_r;
            wlast_r <= (out_row_r == h - 1'b1) && (32'(out_col_r) == 32'(w) - 1);
            if ((32'(out_col_r) + 1 >= 32'(w)) && (out_row_r + 1'b1 >= h)) begin
              // last result of the frame: everything returns to the start
              out_col_r <= '0; out_row_r <= '0; out_addr_r <= '0;
              in_col_r <= '0; in_row_r <= '0; in_addr_r <= '0; lead_r <= '0;
            end else begin
              lead_r     <= lead_r - 1'b1;
              out_addr_r <= (32'(out_addr_r) + 1 == DEPTH) ? '0 : out_addr_r + 1'b1;
              if (32'(out_col_r) + 1 >= 32'(w)) begin
                out_col_r <= '0;
                out_row_r <= out_row_r + 1'b1;
              end else begin
                out_col_r <= out_col_r + 1'b1;
              end
            end
            state_r <= ST_CTR;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_CTR: state_r <= ST_CLAT;
        ST_CLAT: begin
          ctr_label_r <= rd.label;
          ctr_sal_r   <= rd.sal;
          ctr_dist_r  <= rd.distance;
          rad_r <= (32'(adaptive_radius(rd.distance)) > MAX_ADAPTIVE_RADIUS) ?
                   4'(MAX_ADAPTIVE_RADIUS) : adaptive_radius(rd.distance);
          rb_r  <= (waddr_r >= lag_rows) ? waddr_r - lag_rows
                   : AW'((AW+1)'(waddr_r) + (AW+1)'(DEPTH) - (AW+1)'(lag_rows));
          kr_r  <= '0;
          kc_r  <= '0;
          sum_r <= '0;
          cnt_r <= '0;
          state_r <= ST_SWEEP;
        end
        ST_SWEEP: begin
          tag_v_r    <= inimg;
          tag_same_r <= in_same;
          tag_adap_r <= in_adap;
          if (32'(kc_r) == WIN - 1) begin
            kc_r <= '0;
            kr_r <= kr_r + 1'b1;
            rb_r <= (32'(rb_r) + 32'(w) >= DEPTH) ? AW'(32'(rb_r) + 32'(w) - DEPTH)
                    : AW'(32'(rb_r) + 32'(w));
            if (32'(kr_r) == WIN - 1) state_r <= ST_TAIL;
          end else begin
            kc_r <= kc_r + 1'b1;
          end
        end
        ST_TAIL:   state_r <= ST_DSTART;
        ST_DSTART: state_r <= ST_DWAIT;
        ST_DWAIT:  if (div_done) state_r <= ST_DONE;
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_red_r     <= quot[0];
            o_green_r   <= quot[1];
            o_blue_r    <= quot[2];
            o_last_r    <= wlast_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // restart writes at position zero
  logic [AW-1:0] wr_addr;
  assign wr_addr = (in_row_r >= h) ? '0 : in_addr_r;

  sam_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sam_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .sum_i (sum_r),
    .cnt_i (cnt_r),
    .done  (div_done),
    .quot  (quot)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_red       = o_red_r;
  assign out_ch.out_green     = o_green_r;
  assign out_ch.out_blue      = o_blue_r;
  assign out_ch.last_of_frame = o_last_r;

  // the centre always matches itself, so the divisor is never zero
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> cnt_r != '0) else $error("zero pixel count at division");

  // input never runs further ahead than one pixel beyond the lag
  a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(lead_r) <= 32'(lag) + 1) else $error("input lead exceeds window lag");

  // line store is written only while no window sweep is running
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == ST_IDLE) else $error("store write during sweep");

endmodule

FILE: test/segment_aware_mean_filter_core_tb.sv
// Self-checking testbench of the segment-aware mean filter core: random frames against a local predictor.
`timescale 1ns / 1ps

module segment_aware_mean_filter_core_tb;
  import sam_pkg::*;

  localparam int LAG_R       = (DEF_SAME_RADIUS > DEF_MAX_ADAPTIVE_RADIUS) ?
                               DEF_SAME_RADIUS : DEF_MAX_ADAPTIVE_RADIUS;
  localparam int STORE_D     = (2 * LAG_R + 2) * DEF_MAX_WIDTH;
  localparam int SETTLE_CYC  = 200;
  localparam int WDOG_LIMIT  = 5000;
  localparam int RAND_ITEMS  = 860;

  typedef struct packed {
    logic func;
    pix_t px;
  } item_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                last;
  } mean_t;

  logic clk = 1'b0;
  logic rst_n;

  sam_in_if  in_ch ();
  sam_out_if out_ch ();
  sam_cfg_if cfg_ch ();

  segment_aware_mean_filter_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  item_t       pixel_q[$];
  mean_t       mean_q[$];
  int unsigned n_items, n_means, n_cfg, n_mismatch, n_unexpected;

  // predictor state
  pix_t        shadow_store [STORE_D];
  int unsigned width_reg, height_reg;
  int unsigned in_col, in_row, out_col, out_row;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_counters();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic pix_t stored_at(int unsigned row, int unsigned col, int unsigned w);
    return shadow_store[(row * w + col) % STORE_D];
  endfunction

  // label-matched mean, plus the adaptive window for non-salient centres
  function automatic mean_t window_mean(int unsigned row, int unsigned col,
                                        int unsigned w, int unsigned h);
    pix_t        ctr, nb;
    int unsigned sr, sg, sb, cnt, dd, nd, diff, a;
    int          rad, rr, cc;
    mean_t       m;
    ctr = stored_at(row, col, w);
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dr = -DEF_SAME_RADIUS; dr <= DEF_SAME_RADIUS; dr++) begin
      rr = int'(row) + dr;
      if (rr < 0 || rr >= int'(h)) continue;
      for (int dc = -DEF_SAME_RADIUS; dc <= DEF_SAME_RADIUS; dc++) begin
        cc = int'(col) + dc;
        if (cc < 0 || cc >= int'(w)) continue;
        nb = stored_at(rr, cc, w);
        if (nb.label == ctr.label) begin
          sr += 32'(nb.red); sg += 32'(nb.green); sb += 32'(nb.blue); cnt++;
        end
      end
    end
    if (!ctr.sal) begin
      dd = 32'(ctr.distance);
      a = ((10 * dd) >> 12) + 3;
      if (a < 4) a = 4;
      if (a > 9) a = 9;
      rad = a / 2;
      if (rad > DEF_MAX_ADAPTIVE_RADIUS) rad = DEF_MAX_ADAPTIVE_RADIUS;
      for (int dr = -rad; dr <= rad; dr++) begin
        rr = int'(row) + dr;
        if (rr < 0 || rr >= int'(h)) continue;
        for (int dc = -rad; dc <= rad; dc++) begin
          cc = int'(col) + dc;
          if (cc < 0 || cc >= int'(w)) continue;
          nb = stored_at(rr, cc, w);
          nd = 32'(nb.distance);
          diff = (nd > dd) ? nd - dd : dd - nd;
          if (nb.label != ctr.label && 10 * diff < 3 * dd) begin
            sr += 32'(nb.red); sg += 32'(nb.green); sb += 32'(nb.blue); cnt++;
          end
        end
      end
    end
    if (cnt == 0) cnt = 1;
    m.red   = 8'(sr / cnt);
    m.green = 8'(sg / cnt);
    m.blue  = 8'(sb / cnt);
    m.last  = (row == h - 1 && col == w - 1);
    return m;
  endfunction

  // advance the predictor by one accepted item
  function automatic void predict_item(item_t it);
    int unsigned w, h, lag, in_pos, out_pos;
    w = eff_width();
    h = eff_height();
    lag = LAG_R * w + LAG_R;
    if (it.func == FUNC_PIXEL) begin
      if (in_row >= h) restart_counters();
      shadow_store[(in_row * w + in_col) % STORE_D] = it.px;
      in_col++;
      if (in_col >= w) begin
        in_col = 0; in_row++;
      end
    end else if (in_row < h) begin
      return;  // drain before the frame is complete
    end
    in_pos  = in_row * w + in_col;
    out_pos = out_row * w + out_col;
    if (!(in_row >= h || in_pos > out_pos + lag)) return;
    mean_q.push_back(window_mean(out_row, out_col, w, h));
    out_col++;
    if (out_col >= w) begin
      out_col = 0; out_row++;
    end
    if (out_row >= h) restart_counters();
  endfunction

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // input driver
  int unsigned in_wait;
  bit          in_burst;
  item_t       in_cur;

  always @(posedge clk) begin : drv
    item_t nx;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_wait     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_item(in_cur);
        n_items++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (in_wait == 0 && pixel_q.size() > 0) begin
          nx = pixel_q.pop_front();
          in_cur <= nx;
          in_ch.valid         <= 1'b1;
          in_ch.func          <= nx.func;
          in_ch.red           <= nx.px.red;
          in_ch.green         <= nx.px.green;
          in_ch.blue          <= nx.px.blue;
          in_ch.segment_label <= nx.px.label;
          in_ch.salient       <= nx.px.sal;
          in_ch.distance      <= nx.px.distance;
          if ($urandom_range(0, 39) == 0) in_burst <= ~in_burst;
          in_wait <= draw_wait(in_burst);
        end else begin
          in_ch.valid <= 1'b0;
          if (in_wait > 0) in_wait <= in_wait - 1;
        end
      end
    end
  end

  // result monitor and checker
  int unsigned out_wait;
  bit          out_burst;

  always @(posedge clk) begin : mon
    int unsigned nxt;
    mean_t       got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait     <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_red, out_ch.out_green, out_ch.out_blue, out_ch.last_of_frame};
        n_means++;
        if (mean_q.size() == 0) begin
          n_unexpected++;
          if (n_unexpected <= 10) $display("result with nothing pending: %p", got);
        end else begin
          want = mean_q.pop_front();
          if (got !== want) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch at result %0d: exp r%0d g%0d b%0d l%0b got r%0d g%0d b%0d l%0b",
                       n_means, want.red, want.green, want.blue, want.last,
                       got.red, got.green, got.blue, got.last);
          end
        end
        if ($urandom_range(0, 39) == 0) out_burst <= ~out_burst;
        nxt = draw_wait(out_burst);
      end else begin
        nxt = (out_wait > 0) ? out_wait - 1 : 0;
      end
      out_wait     <= nxt;
      out_ch.ready <= (nxt == 0);
    end
  end

  // watchdog on cycles without any transaction
  int unsigned quiet_cyc;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cyc <= 0;
    end else if (quiet_cyc >= WDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cyc <= quiet_cyc + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) width_reg = val & 32'h7FF;
    else                        height_reg = val & 32'h1FFF;
    restart_counters();
    n_cfg++;
  endtask

  // block idle: inputs sent, results in, and any silent work finished
  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_ch.valid || mean_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] lbl,
                            logic sal, logic [15:0] dval);
    item_t it;
    it.func = FUNC_PIXEL;
    it.px   = '{red: r, green: g, blue: b, label: lbl, sal: sal, distance: dval};
    pixel_q.push_back(it);
  endtask

  task automatic push_drain();
    item_t it;
    it.func = FUNC_DRAIN;
    it.px   = PIX_W'({$urandom(), $urandom()});
    pixel_q.push_back(it);
  endtask

  // one frame of random content; broken frames mix in stray and missing drains
  task automatic push_frame(int unsigned w, int unsigned h, bit broken, inout int unsigned cnt);
    int unsigned n, dbase, lmode;
    logic [15:0] d;
    dbase = $urandom_range(0, 16'hFFFF);
    lmode = $urandom_range(0, 3);
    for (int unsigned i = 0; i < w * h; i++) begin
      d = ($urandom_range(0, 2) == 0) ? 16'($urandom()) :
          16'(dbase + $urandom_range(0, 4096) - 2048);
      push_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()),
                 (lmode == 0) ? 8'($urandom()) : 8'($urandom_range(0, lmode)),
                 1'($urandom_range(0, 1)), d);
      cnt++;
      if (broken && $urandom_range(0, 7) == 0) begin
        push_drain();
        cnt++;
      end
    end
    n = (w * h < 5 * w + 6) ? w * h : 5 * w + 6;
    if (broken) n = $urandom_range(0, n);
    repeat (n) begin
      push_drain();
      cnt++;
    end
  endtask

  initial begin
    int unsigned rnd_cnt, dir_cnt, w, h;
    bit          broken;
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.func = FUNC_PIXEL; in_ch.red = '0; in_ch.green = '0;
    in_ch.blue = '0; in_ch.segment_label = '0; in_ch.salient = 1'b0; in_ch.distance = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_IMAGE_WIDTH; cfg_ch.data = '0;
    n_items = 0; n_means = 0; n_cfg = 0; n_mismatch = 0; n_unexpected = 0;
    in_burst = 1'b0; out_burst = 1'b0; quiet_cyc = 0;
    width_reg = WIDTH_RESET; height_reg = HEIGHT_RESET;
    restart_counters();
    rnd_cnt = 0; dir_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: a few pixels, far from the lag, plus a stray drain
    for (int i = 0; i < 4; i++) push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, i[0], 16'hFFFF);
    push_drain();
    wait_idle();

    // oversize width saturates, tall height
    write_reg(CFG_IMAGE_WIDTH, 2047);
    write_reg(CFG_IMAGE_HEIGHT, 4096);
    for (int i = 0; i < 3; i++) push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0, 16'h0000);
    wait_idle();

    // zero sizes act as a single pixel frame
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000);
    push_drain();
    wait_idle();

    // 3x2 frame with extremes, drain mid-frame, pixel before drain done
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 16'hFFFF);
    push_drain();
    push_pixel(8'h80, 8'h7F, 8'h01, 8'h00, 1'b0, 16'h1000);
    push_pixel(8'h10, 8'h20, 8'h30, 8'h01, 1'b1, 16'h1100);
    push_pixel(8'hAA, 8'h55, 8'hCC, 8'h00, 1'b0, 16'h0F00);
    push_pixel(8'hFE, 8'h01, 8'h7E, 8'h02, 1'b0, 16'h1080);
    push_drain();
    push_pixel(8'h01, 8'h02, 8'h03, 8'h00, 1'b0, 16'h2000);
    for (int i = 0; i < 5; i++) push_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                           8'h00, 1'b0, 16'h2000 + 16'(i * 64));
    repeat (6) push_drain();
    dir_cnt = 31;
    wait_idle();

    // widest row, only partially filled
    write_reg(CFG_IMAGE_WIDTH, DEF_MAX_WIDTH);
    write_reg(CFG_IMAGE_HEIGHT, 1);
    for (int i = 0; i < 4; i++) push_pixel(8'($urandom()), 8'($urandom()), 8'($urandom()),
                                           8'h07, 1'b0, 16'($urandom()));
    dir_cnt += 4;
    wait_idle();

    // random phases of small frames
    while (rnd_cnt < RAND_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        w = $urandom_range(1, 3); h = $urandom_range(12, 30);
      end else begin
        w = $urandom_range(1, 14); h = $urandom_range(1, 9);
      end
      if ($urandom_range(0, 3) != 0 || eff_width() != w) write_reg(CFG_IMAGE_WIDTH, w);
      if ($urandom_range(0, 3) != 0 || eff_height() != h) write_reg(CFG_IMAGE_HEIGHT, h);
      repeat ($urandom_range(1, 3)) begin
        broken = ($urandom_range(0, 4) == 0);
        push_frame(w, h, broken, rnd_cnt);
      end
      wait_idle();
    end

    $display("%0d items, %0d results, %0d register writes (%0d directed, %0d random items)",
             n_items, n_means, n_cfg, dir_cnt, rnd_cnt);
    $display("%0d mismatches, %0d unexpected results, %0d still pending",
             n_mismatch, n_unexpected, mean_q.size());
    if (n_mismatch == 0 && n_unexpected == 0 && mean_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
